@@ design/btsc_pkg.sv @@
// Shared types, codes and constants of the battery thermal step controller.
package btsc_pkg;

  localparam int TABLE_DEPTH   = 8;
  localparam int KELVIN_OFFSET = 2730;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;

  typedef enum logic [1:0] {
    OP_EVENT     = 2'd0,
    OP_LOAD_WARM = 2'd1,
    OP_LOAD_COLD = 2'd2,
    OP_START     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_COOL = 2'd0,
    EV_WARM = 2'd1,
    EV_BAD2 = 2'd2,
    EV_BAD3 = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ACT_ENABLE   = 2'd0,
    ACT_DECREASE = 2'd1,
    ACT_STOP     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_WARM_ENTRIES   = 3'd0,
    REG_COLD_ENTRIES   = 3'd1,
    REG_NORMAL_VBATT   = 3'd2,
    REG_REDUCED_VBATT  = 3'd3,
    REG_REDUCED_CURR   = 3'd4,
    REG_SPARE5         = 3'd5,
    REG_SPARE6         = 3'd6,
    REG_SPARE7         = 3'd7
  } reg_t;

  localparam logic [3:0]  RST_WARM_ENTRIES = 4'd1;
  localparam logic [3:0]  RST_COLD_ENTRIES = 4'd1;
  localparam logic [15:0] RST_NORMAL_VBATT = 16'd4350;
  localparam logic [15:0] RST_REDUCED_VBATT = 16'd4100;
  localparam logic [15:0] RST_REDUCED_CURR = 16'd500;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EMIT  = 2'd2,
    S_SPARE = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_WARM  = 2'd1,
    JOB_COOL  = 2'd2,
    JOB_SPARE = 2'd3
  } job_t;

  // One table step, temperatures already in deci-Celsius.
  typedef struct packed {
    logic signed [12:0] trip;
    logic [1:0]         action;
    logic signed [12:0] next_low;
    logic signed [12:0] next_high;
    logic [3:0]         health;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [3:0]  warm_entries;
    logic [3:0]  cold_entries;
    logic [15:0] normal_vbatt_mv;
    logic [15:0] reduced_vbatt_mv;
    logic [15:0] reduced_current_ma;
  } cfg_t;

  function automatic logic signed [12:0] to_decic(input logic [11:0] dk);
    return $signed({1'b0, dk}) - 13'sd2730;
  endfunction

endpackage

@@ design/btsc_if.sv @@
// Handshake channels for step items and result items.
interface btsc_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  event_state;
  logic        charger_online;
  logic [2:0]  entry_index;
  logic [11:0] entry_trip_dk;
  logic [1:0]  entry_action;
  logic [11:0] entry_next_low_dk;
  logic [11:0] entry_next_high_dk;
  logic [3:0]  entry_health;

  modport source (
    output valid, operation, event_state, charger_online, entry_index, entry_trip_dk,
           entry_action, entry_next_low_dk, entry_next_high_dk, entry_health,
    input  ready
  );
  modport sink (
    input  valid, operation, event_state, charger_online, entry_index, entry_trip_dk,
           entry_action, entry_next_low_dk, entry_next_high_dk, entry_health,
    output ready
  );
endinterface

interface btsc_result_if;
  logic               valid;
  logic               ready;
  logic               error;
  logic [1:0]         charge_action;
  logic               health_valid;
  logic [3:0]         health;
  logic signed [12:0] low_threshold;
  logic signed [12:0] high_threshold;
  logic [15:0]        voltage_limit_mv;
  logic [15:0]        current_limit_ma;

  modport source (
    output valid, error, charge_action, health_valid, health, low_threshold,
           high_threshold, voltage_limit_mv, current_limit_ma,
    input  ready
  );
  modport sink (
    input  valid, error, charge_action, health_valid, health, low_threshold,
           high_threshold, voltage_limit_mv, current_limit_ma,
    output ready
  );
endinterface

@@ design/btsc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module btsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/btsc_regs.sv @@
// APB configuration registers of the thermal step controller.
module btsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [btsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [btsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output btsc_pkg::cfg_t                cfg
);

  btsc_pkg::reg_t sel;
  logic           wr;

  assign sel    = btsc_pkg::reg_t'(paddr[btsc_pkg::PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warm_entries       <= btsc_pkg::RST_WARM_ENTRIES;
      cfg.cold_entries       <= btsc_pkg::RST_COLD_ENTRIES;
      cfg.normal_vbatt_mv    <= btsc_pkg::RST_NORMAL_VBATT;
      cfg.reduced_vbatt_mv   <= btsc_pkg::RST_REDUCED_VBATT;
      cfg.reduced_current_ma <= btsc_pkg::RST_REDUCED_CURR;
    end else if (wr) begin
      unique case (sel)
        btsc_pkg::REG_WARM_ENTRIES:  cfg.warm_entries       <= pwdata[3:0];
        btsc_pkg::REG_COLD_ENTRIES:  cfg.cold_entries       <= pwdata[3:0];
        btsc_pkg::REG_NORMAL_VBATT:  cfg.normal_vbatt_mv    <= pwdata[15:0];
        btsc_pkg::REG_REDUCED_VBATT: cfg.reduced_vbatt_mv   <= pwdata[15:0];
        btsc_pkg::REG_REDUCED_CURR:  cfg.reduced_current_ma <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      btsc_pkg::REG_WARM_ENTRIES:  prdata = {28'd0, cfg.warm_entries};
      btsc_pkg::REG_COLD_ENTRIES:  prdata = {28'd0, cfg.cold_entries};
      btsc_pkg::REG_NORMAL_VBATT:  prdata = {16'd0, cfg.normal_vbatt_mv};
      btsc_pkg::REG_REDUCED_VBATT: prdata = {16'd0, cfg.reduced_vbatt_mv};
      btsc_pkg::REG_REDUCED_CURR:  prdata = {16'd0, cfg.reduced_current_ma};
      default:                     prdata = '0;
    endcase
  end

endmodule

@@ design/btsc_walk.sv @@
// Sequencer that loads table steps, walks a table for an event and builds the result beat.
module btsc_walk #(
  parameter int TABLE_DEPTH = btsc_pkg::TABLE_DEPTH,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  btsc_item_if.sink                    item,
  btsc_result_if.source                result,
  input  btsc_pkg::cfg_t               cfg,
  input  btsc_pkg::entry_t             warm_rdata,
  input  btsc_pkg::entry_t             cold_rdata,
  output logic                         warm_we,
  output logic                         cold_we,
  output logic [AW-1:0]                wr_addr,
  output btsc_pkg::entry_t             wr_data,
  output logic [AW-1:0]                rd_addr
);

  btsc_pkg::state_t   state, state_next;
  btsc_pkg::job_t     job, job_next;
  logic [AW-1:0]      idx, idx_next;
  logic               online, online_next;
  logic signed [12:0] low_limit, low_limit_next;
  logic signed [12:0] high_limit, high_limit_next;
  logic               pend_err, pend_err_next;
  logic [1:0]         pend_action, pend_action_next;
  logic               pend_hv, pend_hv_next;
  logic [3:0]         pend_health, pend_health_next;

  btsc_pkg::op_t      op;
  btsc_pkg::event_t   ev;
  btsc_pkg::entry_t   ent;
  logic               accept, load_ok, step, walk_done, out_free;
  logic [AW-1:0]      warm_top, cold_top;

  // Entry counts act as 1 when zero and as the table depth when above it.
  function automatic logic [AW-1:0] top_of(input logic [3:0] n);
    logic [5:0] c;
    if (n == 4'd0) begin
      c = 6'd1;
    end else if (6'(n) > 6'(TABLE_DEPTH)) begin
      c = 6'(TABLE_DEPTH);
    end else begin
      c = 6'(n);
    end
    return AW'(c - 6'd1);
  endfunction

  assign op       = btsc_pkg::op_t'(item.operation);
  assign ev       = btsc_pkg::event_t'(item.event_state);
  assign warm_top = top_of(cfg.warm_entries);
  assign cold_top = top_of(cfg.cold_entries);
  assign accept   = item.valid && item.ready;
  assign load_ok  = 32'(item.entry_index) < TABLE_DEPTH;
  assign out_free = !result.valid || result.ready;
  assign ent      = (job == btsc_pkg::JOB_COOL) ? cold_rdata : warm_rdata;

  assign wr_addr           = AW'(item.entry_index);
  assign wr_data.trip      = btsc_pkg::to_decic(item.entry_trip_dk);
  assign wr_data.action    = item.entry_action;
  assign wr_data.next_low  = btsc_pkg::to_decic(item.entry_next_low_dk);
  assign wr_data.next_high = btsc_pkg::to_decic(item.entry_next_high_dk);
  assign wr_data.health    = item.entry_health;

  // Walk step decision on the entry that the RAM returned this cycle.
  always_comb begin
    step = 1'b0;
    case (job)
      btsc_pkg::JOB_WARM: step = (idx != '0) && (high_limit < ent.trip);
      btsc_pkg::JOB_COOL: step = (idx != cold_top) && (low_limit > ent.trip);
      default:            step = 1'b0;
    endcase
    walk_done = !step;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      btsc_pkg::S_IDLE: begin
        if (accept) begin
          if (op == btsc_pkg::OP_START) begin
            state_next = btsc_pkg::S_FETCH;
          end else if (op == btsc_pkg::OP_EVENT) begin
            state_next = (ev == btsc_pkg::EV_COOL || ev == btsc_pkg::EV_WARM) ?
                         btsc_pkg::S_FETCH : btsc_pkg::S_EMIT;
          end
        end
      end
      btsc_pkg::S_FETCH: begin
        if (walk_done) begin
          state_next = btsc_pkg::S_EMIT;
        end
      end
      btsc_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = btsc_pkg::S_IDLE;
        end
      end
      default: state_next = btsc_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath next values.
  always_comb begin
    item.ready       = (state == btsc_pkg::S_IDLE);
    warm_we          = accept && (op == btsc_pkg::OP_LOAD_WARM) && load_ok;
    cold_we          = accept && (op == btsc_pkg::OP_LOAD_COLD) && load_ok;
    rd_addr          = '0;
    job_next         = job;
    idx_next         = idx;
    online_next      = online;
    low_limit_next   = low_limit;
    high_limit_next  = high_limit;
    pend_err_next    = pend_err;
    pend_action_next = pend_action;
    pend_hv_next     = pend_hv;
    pend_health_next = pend_health;
    unique case (state)
      btsc_pkg::S_IDLE: begin
        online_next = item.charger_online;
        if (op == btsc_pkg::OP_START) begin
          job_next = btsc_pkg::JOB_START;
          idx_next = '0;
        end else if (ev == btsc_pkg::EV_WARM) begin
          job_next = btsc_pkg::JOB_WARM;
          idx_next = warm_top;
        end else begin
          job_next = btsc_pkg::JOB_COOL;
          idx_next = '0;
        end
        rd_addr = idx_next;
        // An invalid event state reports the current thresholds unchanged.
        pend_err_next    = 1'b1;
        pend_action_next = btsc_pkg::ACT_NONE;
        pend_hv_next     = 1'b0;
        pend_health_next = '0;
      end
      btsc_pkg::S_FETCH: begin
        if (step) begin
          idx_next = (job == btsc_pkg::JOB_WARM) ? idx - AW'(1) : idx + AW'(1);
        end else begin
          low_limit_next  = ent.next_low;
          high_limit_next = ent.next_high;
          pend_err_next   = 1'b0;
          if (job == btsc_pkg::JOB_START) begin
            pend_action_next = online ? btsc_pkg::ACT_ENABLE : btsc_pkg::ACT_NONE;
            pend_hv_next     = 1'b0;
            pend_health_next = '0;
          end else begin
            pend_action_next = online ? ent.action : btsc_pkg::ACT_NONE;
            pend_hv_next     = 1'b1;
            pend_health_next = ent.health;
          end
        end
        rd_addr = idx_next;
      end
      btsc_pkg::S_EMIT: begin
        rd_addr = idx;
      end
      default: begin
        rd_addr = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= btsc_pkg::S_IDLE;
      low_limit    <= '0;
      high_limit   <= '0;
      result.valid <= 1'b0;
    end else begin
      state      <= state_next;
      low_limit  <= low_limit_next;
      high_limit <= high_limit_next;
      if (state == btsc_pkg::S_EMIT && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job         <= job_next;
    idx         <= idx_next;
    online      <= online_next;
    pend_err    <= pend_err_next;
    pend_action <= pend_action_next;
    pend_hv     <= pend_hv_next;
    pend_health <= pend_health_next;
    if (state == btsc_pkg::S_EMIT && out_free) begin
      result.error          <= pend_err;
      result.charge_action  <= pend_action;
      result.health_valid   <= pend_hv;
      result.health         <= pend_health;
      result.low_threshold  <= low_limit;
      result.high_threshold <= high_limit;
      case (pend_action)
        btsc_pkg::ACT_ENABLE: begin
          result.voltage_limit_mv <= cfg.normal_vbatt_mv;
          result.current_limit_ma <= '0;
        end
        btsc_pkg::ACT_DECREASE: begin
          result.voltage_limit_mv <= cfg.reduced_vbatt_mv;
          result.current_limit_ma <= cfg.reduced_current_ma;
        end
        default: begin
          result.voltage_limit_mv <= '0;
          result.current_limit_ma <= '0;
        end
      endcase
    end
  end

endmodule

@@ design/battery_thermal_step_controller.sv @@
// Top level of the battery thermal step controller.
// Usage: the item channel carries loads of warm or cold table steps, start items
// and threshold events; the result channel returns one beat per start or event
// and none per load. Temperatures arrive in deci-kelvin and leave in
// deci-Celsius. Limits and entry counts are set over the APB port while idle.
// Sequence: a load is written on the clock edge that accepts it, and the item
// channel stays ready for the next item. A start reads warm entry 0 and then
// emits its beat, an invalid event goes straight to the emit state, and a warm
// or cool event first visits k table entries (1 to the entry count); each visit is
// one read of the step RAM, whose registered read port sets the pace of the walk.
// One item is in flight at a time: the next item is accepted once the result
// has moved to the output register.
// If the receiver stalls, the result stays held and a following event waits
// in the emit state until that register is free.
// Reset clears the current thresholds, the result valid flag and the sequencer
// and restores the register defaults; table contents are not cleared and must
// be loaded before they are used.
module battery_thermal_step_controller #(
  parameter int TABLE_DEPTH = btsc_pkg::TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  btsc_item_if.sink                     item,
  btsc_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [btsc_pkg::PADDR_W-1:0]  paddr,
  input  logic [btsc_pkg::PDATA_W-1:0]  pwdata,
  output logic [btsc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  btsc_pkg::cfg_t   cfg;
  btsc_pkg::entry_t warm_rdata, cold_rdata, wr_data;
  logic             warm_we, cold_we;
  logic [AW-1:0]    wr_addr, rd_addr;

  btsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  btsc_ram #(
    .WIDTH (btsc_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_warm_ram (
    .clk   (clk),
    .we    (warm_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (warm_rdata)
  );

  btsc_ram #(
    .WIDTH (btsc_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cold_ram (
    .clk   (clk),
    .we    (cold_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (cold_rdata)
  );

  btsc_walk #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .cfg        (cfg),
    .warm_rdata (warm_rdata),
    .cold_rdata (cold_rdata),
    .warm_we    (warm_we),
    .cold_we    (cold_we),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the battery thermal step controller.
module testbench;

  localparam int CLK_HALF        = 2;
  localparam int RUN_LIMIT       = 1_000_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 400;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    btsc_pkg::op_t     operation;
    btsc_pkg::event_t  event_state;
    logic              online;
    logic [2:0]        idx;
    logic [11:0]       trip_dk;
    btsc_pkg::action_t act;
    logic [11:0]       low_dk;
    logic [11:0]       high_dk;
    logic [3:0]        health;
  } step_item_t;

  typedef struct packed {
    logic               err;
    btsc_pkg::action_t  act;
    logic               hv;
    logic [3:0]         health;
    logic signed [12:0] low;
    logic signed [12:0] high;
    logic [15:0]        volt;
    logic [15:0]        curr;
  } decision_t;

  typedef struct packed {
    step_item_t item;
    logic       typed;
    decision_t  want;
  } script_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [btsc_pkg::PADDR_W-1:0] paddr;
  logic [btsc_pkg::PDATA_W-1:0] pwdata;
  logic [btsc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  btsc_item_if   item_ch ();
  btsc_result_if result_ch ();

  battery_thermal_step_controller dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the controller state, kept in step with accepted beats.
  btsc_pkg::entry_t                 warm_steps [btsc_pkg::TABLE_DEPTH];
  btsc_pkg::entry_t                 cold_steps [btsc_pkg::TABLE_DEPTH];
  logic [btsc_pkg::TABLE_DEPTH-1:0] warm_loaded;
  logic [btsc_pkg::TABLE_DEPTH-1:0] cold_loaded;
  logic signed [12:0]               cur_low;
  logic signed [12:0]               cur_high;
  btsc_pkg::cfg_t                   regs;

  decision_t   decision_q [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [12:0] dk_to_dc(input logic [11:0] dk);
    return 13'(int'(dk) - btsc_pkg::KELVIN_OFFSET);
  endfunction

  function automatic int entries_in_use(input logic [3:0] count);
    if (count == 0) return 1;
    if (int'(count) > btsc_pkg::TABLE_DEPTH) return btsc_pkg::TABLE_DEPTH;
    return int'(count);
  endfunction

  function automatic btsc_pkg::entry_t as_entry(input step_item_t it);
    btsc_pkg::entry_t e;
    e.trip      = dk_to_dc(it.trip_dk);
    e.action    = it.act;
    e.next_low  = dk_to_dc(it.low_dk);
    e.next_high = dk_to_dc(it.high_dk);
    e.health    = it.health;
    return e;
  endfunction

  function automatic decision_t outcome(input logic err, input btsc_pkg::action_t act,
                                        input logic hv, input logic [3:0] health);
    decision_t d;
    d.err    = err;
    d.act    = act;
    d.hv     = hv;
    d.health = health;
    d.low    = cur_low;
    d.high   = cur_high;
    d.volt   = act == btsc_pkg::ACT_ENABLE ? regs.normal_vbatt_mv :
               act == btsc_pkg::ACT_DECREASE ? regs.reduced_vbatt_mv : 16'd0;
    d.curr   = act == btsc_pkg::ACT_DECREASE ? regs.reduced_current_ma : 16'd0;
    return d;
  endfunction

  // Applies one accepted item to the mirror and returns the beat it should cause.
  task automatic compute_charge_decision(input step_item_t it, output bit produced,
                                         output decision_t d);
    btsc_pkg::entry_t e;
    int               k;
    int               n;
    produced = 1'b1;
    d        = '0;
    case (it.operation)
      btsc_pkg::OP_LOAD_WARM: begin
        warm_steps[it.idx]  = as_entry(it);
        warm_loaded[it.idx] = 1'b1;
        produced            = 1'b0;
      end
      btsc_pkg::OP_LOAD_COLD: begin
        cold_steps[it.idx]  = as_entry(it);
        cold_loaded[it.idx] = 1'b1;
        produced            = 1'b0;
      end
      btsc_pkg::OP_START: begin
        cur_low  = warm_steps[0].next_low;
        cur_high = warm_steps[0].next_high;
        d = outcome(1'b0, it.online ? btsc_pkg::ACT_ENABLE : btsc_pkg::ACT_NONE, 1'b0, 4'd0);
      end
      default: begin
        if (it.event_state == btsc_pkg::EV_BAD2 || it.event_state == btsc_pkg::EV_BAD3) begin
          d = outcome(1'b1, btsc_pkg::ACT_NONE, 1'b0, 4'd0);
        end else begin
          if (it.event_state == btsc_pkg::EV_WARM) begin
            // Walk down from the top entry while the trip is above the high threshold.
            n = entries_in_use(regs.warm_entries);
            k = n - 1;
            while (k > 0 && cur_high < warm_steps[k].trip) k--;
            e = warm_steps[k];
          end else begin
            n = entries_in_use(regs.cold_entries);
            k = 0;
            while (k < n - 1 && cur_low > cold_steps[k].trip) k++;
            e = cold_steps[k];
          end
          cur_low  = e.next_low;
          cur_high = e.next_high;
          d = outcome(1'b0, it.online ? btsc_pkg::action_t'(e.action) : btsc_pkg::ACT_NONE,
                      1'b1, e.health);
        end
      end
    endcase
  endtask

  function automatic int idle_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] pick_dk();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'd4095;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic step_item_t random_step();
    step_item_t it;
    int         r;
    int         need_warm;
    int         need_cold;
    r = $urandom_range(99);
    it.operation   = r < 18 ? btsc_pkg::OP_LOAD_WARM :
                     r < 36 ? btsc_pkg::OP_LOAD_COLD :
                     r < 43 ? btsc_pkg::OP_START : btsc_pkg::OP_EVENT;
    it.event_state = ($urandom_range(9) == 0) ? btsc_pkg::event_t'($urandom_range(2, 3))
                                              : btsc_pkg::event_t'($urandom_range(1));
    it.online      = ($urandom_range(7) != 0);
    it.idx         = 3'($urandom);
    it.trip_dk     = pick_dk();
    it.act         = btsc_pkg::action_t'($urandom_range(3));
    it.low_dk      = pick_dk();
    it.high_dk     = pick_dk();
    it.health      = 4'($urandom);
    need_warm = it.operation == btsc_pkg::OP_START ? 1 :
                (it.operation == btsc_pkg::OP_EVENT && it.event_state == btsc_pkg::EV_WARM) ?
                entries_in_use(regs.warm_entries) : 0;
    need_cold = (it.operation == btsc_pkg::OP_EVENT && it.event_state == btsc_pkg::EV_COOL) ?
                entries_in_use(regs.cold_entries) : 0;
    // Never walk into a step that was not loaded yet: load the missing one instead.
    for (int k = 0; k < btsc_pkg::TABLE_DEPTH; k++) begin
      if (k < need_warm && !warm_loaded[k]) begin
        it.operation = btsc_pkg::OP_LOAD_WARM;
        it.idx       = 3'(k);
      end
      if (k < need_cold && !cold_loaded[k]) begin
        it.operation = btsc_pkg::OP_LOAD_COLD;
        it.idx       = 3'(k);
      end
    end
    return it;
  endfunction

  function automatic step_item_t mk_step(input btsc_pkg::op_t op, input btsc_pkg::event_t ev,
                                         input logic online, input int idx, input int trip,
                                         input btsc_pkg::action_t act, input int low,
                                         input int high, input int health);
    step_item_t it;
    it.operation   = op;
    it.event_state = ev;
    it.online      = online;
    it.idx         = 3'(idx);
    it.trip_dk     = 12'(trip);
    it.act         = act;
    it.low_dk      = 12'(low);
    it.high_dk     = 12'(high);
    it.health      = 4'(health);
    return it;
  endfunction

  function automatic decision_t mk_decision(input logic err, input btsc_pkg::action_t act,
                                            input logic hv, input int health, input int low,
                                            input int high, input int volt, input int curr);
    decision_t d;
    d.err    = err;
    d.act    = act;
    d.hv     = hv;
    d.health = 4'(health);
    d.low    = 13'(low);
    d.high   = 13'(high);
    d.volt   = 16'(volt);
    d.curr   = 16'(curr);
    return d;
  endfunction

  task automatic script_row(input step_item_t it, input logic typed, input decision_t want);
    script_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endtask

  function automatic string describe(input decision_t d);
    return $sformatf("err=%0b act=%s hv=%0b health=%0d low=%0d high=%0d volt=%0d curr=%0d",
                     d.err, d.act.name(), d.hv, d.health, d.low, d.high, d.volt, d.curr);
  endfunction

  task automatic offer_step(input step_item_t it, input logic typed, input decision_t want,
                            input bit calm);
    bit        produced;
    decision_t d;
    int        gap;
    item_ch.valid              <= 1'b1;
    item_ch.operation          <= it.operation;
    item_ch.event_state        <= it.event_state;
    item_ch.charger_online     <= it.online;
    item_ch.entry_index        <= it.idx;
    item_ch.entry_trip_dk      <= it.trip_dk;
    item_ch.entry_action       <= it.act;
    item_ch.entry_next_low_dk  <= it.low_dk;
    item_ch.entry_next_high_dk <= it.high_dk;
    item_ch.entry_health       <= it.health;
    do @(posedge clk); while (!item_ch.ready);
    compute_charge_decision(it, produced, d);
    if (produced) decision_q.push_back(typed ? want : d);
    gap = idle_gap(calm);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes a register, reads it back and updates the mirror.
  task automatic write_reg(input btsc_pkg::reg_t r, input logic [15:0] value);
    logic [btsc_pkg::PDATA_W-1:0] stored;
    logic [btsc_pkg::PDATA_W-1:0] seen;
    case (r)
      btsc_pkg::REG_WARM_ENTRIES: begin
        regs.warm_entries = value[3:0];
        stored = btsc_pkg::PDATA_W'(value[3:0]);
      end
      btsc_pkg::REG_COLD_ENTRIES: begin
        regs.cold_entries = value[3:0];
        stored = btsc_pkg::PDATA_W'(value[3:0]);
      end
      btsc_pkg::REG_NORMAL_VBATT: begin
        regs.normal_vbatt_mv = value;
        stored = btsc_pkg::PDATA_W'(value);
      end
      btsc_pkg::REG_REDUCED_VBATT: begin
        regs.reduced_vbatt_mv = value;
        stored = btsc_pkg::PDATA_W'(value);
      end
      btsc_pkg::REG_REDUCED_CURR: begin
        regs.reduced_current_ma = value;
        stored = btsc_pkg::PDATA_W'(value);
      end
      default: stored = '0;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= btsc_pkg::PADDR_W'({r, 2'b00});
    pwdata  <= stored;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (seen !== stored) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("register %s: expected %0h, read back %0h", r.name(), stored, seen);
    end
  endtask

  always @(posedge clk) begin : check_beats
    decision_t got;
    decision_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.err    = result_ch.error;
      got.act    = btsc_pkg::action_t'(result_ch.charge_action);
      got.hv     = result_ch.health_valid;
      got.health = result_ch.health;
      got.low    = result_ch.low_threshold;
      got.high   = result_ch.high_threshold;
      got.volt   = result_ch.voltage_limit_mv;
      got.curr   = result_ch.current_limit_ma;
      results_seen++;
      if (decision_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("beat with nothing expected: %s", describe(got));
      end else begin
        want = decision_q.pop_front();
        if (got.err !== want.err || got.act !== want.act || got.hv !== want.hv ||
            got.health !== want.health || got.low !== want.low || got.high !== want.high ||
            got.volt !== want.volt || got.curr !== want.curr) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("beat %0d mismatch", results_seen);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    end
  end

  initial begin : receiver
    int pause;
    int hold_mark;
    int turn;
    bit calm;
    hold_mark = 120;
    turn      = 0;
    calm      = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (turn % 100 == 0) calm = ($urandom_range(2) == 0);
      turn++;
      pause = idle_gap(calm);
      if (results_seen >= hold_mark) begin
        // Keep the output register full long enough for the item input to back up.
        pause = HOLD_CYCLES;
        hold_mark += 600;
      end
      if (pause > 0) begin
        result_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    bit          calm;
    decision_t   nothing;
    logic [3:0]  warm_count;
    logic [3:0]  cold_count;
    logic [15:0] normal_mv;
    logic [15:0] reduced_mv;
    logic [15:0] reduced_ma;
    nothing      = '0;
    warm_loaded  = '0;
    cold_loaded  = '0;
    cur_low      = '0;
    cur_high     = '0;
    regs.warm_entries       = btsc_pkg::RST_WARM_ENTRIES;
    regs.cold_entries       = btsc_pkg::RST_COLD_ENTRIES;
    regs.normal_vbatt_mv    = btsc_pkg::RST_NORMAL_VBATT;
    regs.reduced_vbatt_mv   = btsc_pkg::RST_REDUCED_VBATT;
    regs.reduced_current_ma = btsc_pkg::RST_REDUCED_CURR;

    rst                        <= 1'b1;
    psel                       <= 1'b0;
    penable                    <= 1'b0;
    pwrite                     <= 1'b0;
    paddr                      <= '0;
    pwdata                     <= '0;
    item_ch.valid              <= 1'b0;
    item_ch.operation          <= btsc_pkg::OP_EVENT;
    item_ch.event_state        <= btsc_pkg::EV_COOL;
    item_ch.charger_online     <= 1'b0;
    item_ch.entry_index        <= '0;
    item_ch.entry_trip_dk      <= '0;
    item_ch.entry_action       <= btsc_pkg::ACT_ENABLE;
    item_ch.entry_next_low_dk  <= '0;
    item_ch.entry_next_high_dk <= '0;
    item_ch.entry_health       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps under the reset register values, one table entry in use.
    script_row(mk_step(btsc_pkg::OP_LOAD_WARM, btsc_pkg::EV_COOL, 1, 0, 2730,
                       btsc_pkg::ACT_ENABLE, 0, 4095, 0), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_START, btsc_pkg::EV_COOL, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_ENABLE, 0, 0, -2730, 1365, 4350, 0));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_BAD2, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(1, btsc_pkg::ACT_NONE, 0, 0, -2730, 1365, 0, 0));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_BAD3, 0, 7, 4095,
                       btsc_pkg::ACT_NONE, 4095, 4095, 15), 1,
               mk_decision(1, btsc_pkg::ACT_NONE, 0, 0, -2730, 1365, 0, 0));
    script_row(mk_step(btsc_pkg::OP_START, btsc_pkg::EV_WARM, 0, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_NONE, 0, 0, -2730, 1365, 0, 0));
    script_row(mk_step(btsc_pkg::OP_LOAD_COLD, btsc_pkg::EV_COOL, 1, 0, 4095,
                       btsc_pkg::ACT_STOP, 4095, 0, 15), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_COOL, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_STOP, 1, 15, 1365, -2730, 0, 0));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_WARM, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_ENABLE, 1, 0, -2730, 1365, 4350, 0));
    script_row(mk_step(btsc_pkg::OP_LOAD_WARM, btsc_pkg::EV_COOL, 1, 0, 0,
                       btsc_pkg::ACT_DECREASE, 2730, 2730, 9), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_WARM, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_DECREASE, 1, 9, 0, 0, 4100, 500));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_WARM, 0, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_LOAD_COLD, btsc_pkg::EV_COOL, 1, 7, 4095,
                       btsc_pkg::ACT_NONE, 1, 4094, 5), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_LOAD_WARM, btsc_pkg::EV_COOL, 1, 7, 0,
                       btsc_pkg::ACT_NONE, 4094, 1, 10), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_START, btsc_pkg::EV_COOL, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_ENABLE, 0, 0, 0, 0, 4350, 0));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_COOL, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_STOP, 1, 15, 1365, -2730, 0, 0));
    script_row(mk_step(btsc_pkg::OP_LOAD_WARM, btsc_pkg::EV_COOL, 1, 0, 4095,
                       btsc_pkg::ACT_NONE, 100, 4000, 3), 0, nothing);
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_WARM, 1, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 1,
               mk_decision(0, btsc_pkg::ACT_NONE, 1, 3, -2630, 1270, 0, 0));
    script_row(mk_step(btsc_pkg::OP_EVENT, btsc_pkg::EV_COOL, 0, 0, 0,
                       btsc_pkg::ACT_ENABLE, 0, 0, 0), 0, nothing);
    foreach (script[i]) offer_step(script[i].item, script[i].typed, script[i].want, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      item_ch.valid <= 1'b0;
      while (decision_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin
          // A count of zero must behave as a single entry.
          warm_count = 4'd0;
          cold_count = 4'd0;
          normal_mv  = 16'd0;
          reduced_mv = 16'd0;
          reduced_ma = 16'd0;
        end
        1: begin
          warm_count = 4'd15;
          cold_count = 4'd15;
          normal_mv  = 16'hFFFF;
          reduced_mv = 16'hFFFF;
          reduced_ma = 16'hFFFF;
        end
        2: begin
          warm_count = 4'd8;
          cold_count = 4'd8;
          normal_mv  = 16'($urandom);
          reduced_mv = 16'($urandom);
          reduced_ma = 16'($urandom);
        end
        default: begin
          warm_count = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
          cold_count = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
          normal_mv  = 16'($urandom);
          reduced_mv = 16'($urandom);
          reduced_ma = 16'($urandom);
        end
      endcase
      write_reg(btsc_pkg::REG_WARM_ENTRIES, 16'(warm_count));
      write_reg(btsc_pkg::REG_COLD_ENTRIES, 16'(cold_count));
      write_reg(btsc_pkg::REG_NORMAL_VBATT, normal_mv);
      write_reg(btsc_pkg::REG_REDUCED_VBATT, reduced_mv);
      write_reg(btsc_pkg::REG_REDUCED_CURR, reduced_ma);
      calm = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(3) == 0);
        offer_step(random_step(), 1'b0, nothing, calm);
      end
    end

    item_ch.valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
